>>> sv/tlfc_pkg.sv
// Shared types and constants for the two-level FIFO cache.
// Used by tlfc_cell, tlfc_row and two_level_fifo_cache_top.

package tlfc_pkg;

	localparam int NEAR_ENTRIES_DEF = 64;
	localparam int FAR_ENTRIES_DEF = 128;
	localparam int ADDR_BITS_DEF = 10;
	localparam int WORD_BITS_DEF = 32;

	localparam logic [1:0] LVL_NEAR = 2'd0;
	localparam logic [1:0] LVL_FAR = 2'd1;
	localparam logic [1:0] LVL_MISS = 2'd2;

	typedef struct packed {
		logic look;
		logic upd;
		logic fill;
		logic shift;
	} cell_ctl_t;

endpackage

>>> sv/tlfc_cell.sv
// One cache slot: valid bit, tag and word, plus one stage of the priority token chain.
// Depends on tlfc_pkg for the control struct.

module tlfc_cell import tlfc_pkg::*; #(
	parameter int ADDR_BITS = ADDR_BITS_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int IDX_BITS = 1,
	parameter int IDX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cell_ctl_t            ctl,
	input  logic [IDX_BITS-1:0]  fill_idx,
	input  logic [ADDR_BITS-1:0] key,
	input  logic [WORD_BITS-1:0] new_word,
	input  logic [ADDR_BITS-1:0] nb_tag,
	input  logic [WORD_BITS-1:0] nb_word,
	output logic [ADDR_BITS-1:0] tag,
	output logic [WORD_BITS-1:0] word_fwd,
	input  logic                 tok_in_v,
	input  logic                 tok_in_hit,
	input  logic [WORD_BITS-1:0] tok_in_word,
	output logic                 tok_v,
	output logic                 tok_hit,
	output logic [WORD_BITS-1:0] tok_word
);

	logic                 valid_q;
	logic [ADDR_BITS-1:0] tag_q;
	logic [WORD_BITS-1:0] word_q;
	logic                 match_q;
	logic                 tok_v_q;
	logic                 tok_hit_q;
	logic [WORD_BITS-1:0] tok_word_q;
	logic                 fill_me;

	assign fill_me = ctl.fill && (fill_idx == IDX_BITS'(IDX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_v_q <= 1'b0;
		end else begin
			if (fill_me || ctl.shift) begin
				valid_q <= 1'b1;
			end
			tok_v_q <= tok_in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			tag_q <= nb_tag;
			word_q <= nb_word;
		end else if (fill_me) begin
			tag_q <= key;
			word_q <= new_word;
		end else if (ctl.upd && match_q) begin
			word_q <= new_word;
		end
		if (ctl.look) begin
			match_q <= valid_q && (tag_q == key);
		end
		tok_hit_q <= tok_in_hit | match_q;
		tok_word_q <= match_q ? word_q : tok_in_word;
	end

	assign tag = tag_q;
	assign word_fwd = (ctl.upd && match_q) ? new_word : word_q;
	assign tok_v = tok_v_q;
	assign tok_hit = tok_hit_q;
	assign tok_word = tok_word_q;

endmodule

>>> sv/tlfc_row.sv
// One cache level: a chain of tlfc_cell slots that shift toward slot 0 and pass
// the priority token from the top slot down. Depends on tlfc_pkg and tlfc_cell.

module tlfc_row import tlfc_pkg::*; #(
	parameter int ENTRIES = NEAR_ENTRIES_DEF,
	parameter int ADDR_BITS = ADDR_BITS_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF,
	localparam int IDX_BITS = $clog2(ENTRIES)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cell_ctl_t            ctl,
	input  logic [IDX_BITS-1:0]  fill_idx,
	input  logic [ADDR_BITS-1:0] key,
	input  logic [WORD_BITS-1:0] new_word,
	input  logic [ADDR_BITS-1:0] top_tag,
	input  logic [WORD_BITS-1:0] top_word,
	output logic [ADDR_BITS-1:0] bot_tag,
	output logic [WORD_BITS-1:0] bot_word,
	input  logic                 start,
	output logic                 res_v,
	output logic                 res_hit,
	output logic [WORD_BITS-1:0] res_word
);

	logic [ADDR_BITS-1:0] tag_w [ENTRIES];
	logic [WORD_BITS-1:0] fwd_w [ENTRIES];
	logic                 tv_w [ENTRIES];
	logic                 th_w [ENTRIES];
	logic [WORD_BITS-1:0] tw_w [ENTRIES];

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		logic [ADDR_BITS-1:0] nb_tag;
		logic [WORD_BITS-1:0] nb_word;
		logic                 in_v;
		logic                 in_hit;
		logic [WORD_BITS-1:0] in_word;

		if (i == ENTRIES - 1) begin : g_top
			assign nb_tag = top_tag;
			assign nb_word = top_word;
			assign in_v = start;
			assign in_hit = 1'b0;
			assign in_word = '0;
		end else begin : g_mid
			assign nb_tag = tag_w[i+1];
			assign nb_word = fwd_w[i+1];
			assign in_v = tv_w[i+1];
			assign in_hit = th_w[i+1];
			assign in_word = tw_w[i+1];
		end

		tlfc_cell #(
			.ADDR_BITS(ADDR_BITS),
			.WORD_BITS(WORD_BITS),
			.IDX_BITS(IDX_BITS),
			.IDX(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.fill_idx(fill_idx),
			.key(key),
			.new_word(new_word),
			.nb_tag(nb_tag),
			.nb_word(nb_word),
			.tag(tag_w[i]),
			.word_fwd(fwd_w[i]),
			.tok_in_v(in_v),
			.tok_in_hit(in_hit),
			.tok_in_word(in_word),
			.tok_v(tv_w[i]),
			.tok_hit(th_w[i]),
			.tok_word(tw_w[i])
		);
	end

	assign bot_tag = tag_w[0];
	assign bot_word = fwd_w[0];
	assign res_v = tv_w[0];
	assign res_hit = th_w[0];
	assign res_word = tw_w[0];

endmodule

>>> sv/two_level_fifo_cache_top.sv
// Top level of the two-level fully associative FIFO cache with a victim level.
// Depends on tlfc_pkg and tlfc_row (which builds on tlfc_cell).
//
// Channel  Dir  Fields (lowest bit first)
// s_*      in   tuser: mode; tdata: address, write_data, memory_word, zero fill
// m_*      out  tuser: hit_level; tdata: read_data, zero fill
//
// Each access, from accept to result, waits for a token to walk each row's cell chain
// from its top slot down to slot 0, one slot a cycle, to pick the lowest matching slot;
// the longer chain sets when the result is ready.
// Reset clears all valid bits and fill counts at once; no clearing pass follows.
// A held result in the output register stalls only the final update cycle.

module two_level_fifo_cache_top import tlfc_pkg::*; #(
	parameter int NEAR_ENTRIES = NEAR_ENTRIES_DEF,
	parameter int FAR_ENTRIES = FAR_ENTRIES_DEF,
	parameter int ADDR_BITS = ADDR_BITS_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF,
	localparam int S_DATA_BITS = ((ADDR_BITS + 2 * WORD_BITS + 7) / 8) * 8,
	localparam int M_DATA_BITS = ((WORD_BITS + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [S_DATA_BITS-1:0] s_tdata,  // address, write_data, memory_word
	input  logic                   s_tuser,  // mode
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [M_DATA_BITS-1:0] m_tdata,  // read_data
	output logic [1:0]             m_tuser   // hit_level
);

	localparam int NB = $clog2(NEAR_ENTRIES);
	localparam int FB = $clog2(FAR_ENTRIES);
	localparam int NCB = $clog2(NEAR_ENTRIES + 1);
	localparam int FCB = $clog2(FAR_ENTRIES + 1);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_LOOK   = 4'b0010,
		ST_SCAN   = 4'b0100,
		ST_COMMIT = 4'b1000
	} state_t;

	state_t               state_q;
	logic                 mode_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [WORD_BITS-1:0] wdata_q;
	logic [WORD_BITS-1:0] mword_q;
	logic                 start_q;
	logic                 near_done_q;
	logic                 far_done_q;
	logic                 near_hit_q;
	logic                 far_hit_q;
	logic [WORD_BITS-1:0] near_word_q;
	logic [WORD_BITS-1:0] far_word_q;
	logic [NCB-1:0]       near_cnt_q;
	logic [FCB-1:0]       far_cnt_q;
	logic                 out_valid_q;
	logic [WORD_BITS-1:0] out_data_q;
	logic [1:0]           out_level_q;

	logic                 accept;
	logic                 fire;
	logic                 near_full;
	logic                 far_full;
	logic                 do_insert;
	logic [WORD_BITS-1:0] ins_word;
	logic [WORD_BITS-1:0] res_data;
	logic [1:0]           res_level;
	cell_ctl_t            near_ctl;
	cell_ctl_t            far_ctl;

	logic [ADDR_BITS-1:0] near_bot_tag;
	logic [WORD_BITS-1:0] near_bot_word;
	logic [ADDR_BITS-1:0] far_bot_tag;
	logic [WORD_BITS-1:0] far_bot_word;
	logic                 near_res_v;
	logic                 near_res_hit;
	logic [WORD_BITS-1:0] near_res_word;
	logic                 far_res_v;
	logic                 far_res_hit;
	logic [WORD_BITS-1:0] far_res_word;

	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign fire = (state_q == ST_COMMIT) && (!out_valid_q || m_tready);

	assign near_full = (near_cnt_q == NCB'(NEAR_ENTRIES));
	assign far_full = (far_cnt_q == FCB'(FAR_ENTRIES));
	assign do_insert = mode_q || (!near_hit_q && !far_hit_q);
	assign ins_word = mode_q ? wdata_q : mword_q;

	always_comb begin
		if (near_hit_q) begin
			res_level = LVL_NEAR;
			res_data = near_word_q;
		end else if (far_hit_q) begin
			res_level = LVL_FAR;
			res_data = far_word_q;
		end else begin
			res_level = LVL_MISS;
			res_data = mword_q;
		end
		if (mode_q) begin
			res_data = '0;
		end
	end

	always_comb begin
		near_ctl.look = (state_q == ST_LOOK);
		near_ctl.upd = fire && mode_q && near_hit_q;
		near_ctl.fill = fire && do_insert && !near_full;
		near_ctl.shift = fire && do_insert && near_full && far_full;
		far_ctl.look = (state_q == ST_LOOK);
		far_ctl.upd = fire && mode_q && !near_hit_q && far_hit_q;
		far_ctl.fill = fire && do_insert && near_full && !far_full;
		far_ctl.shift = near_ctl.shift;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
			near_done_q <= 1'b0;
			far_done_q <= 1'b0;
			near_cnt_q <= '0;
			far_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= (state_q == ST_LOOK);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					near_done_q <= 1'b0;
					far_done_q <= 1'b0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (near_res_v) begin
						near_done_q <= 1'b1;
					end
					if (far_res_v) begin
						far_done_q <= 1'b1;
					end
					if (near_done_q && far_done_q) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (near_ctl.fill) begin
				near_cnt_q <= near_cnt_q + NCB'(1);
			end
			if (far_ctl.fill) begin
				far_cnt_q <= far_cnt_q + FCB'(1);
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= s_tuser;
			addr_q <= s_tdata[ADDR_BITS-1:0];
			wdata_q <= s_tdata[ADDR_BITS +: WORD_BITS];
			mword_q <= s_tdata[ADDR_BITS + WORD_BITS +: WORD_BITS];
		end
		if (near_res_v) begin
			near_hit_q <= near_res_hit;
			near_word_q <= near_res_word;
		end
		if (far_res_v) begin
			far_hit_q <= far_res_hit;
			far_word_q <= far_res_word;
		end
		if (fire) begin
			out_data_q <= res_data;
			out_level_q <= res_level;
		end
	end

	tlfc_row #(
		.ENTRIES(NEAR_ENTRIES),
		.ADDR_BITS(ADDR_BITS),
		.WORD_BITS(WORD_BITS)
	) u_near (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(near_ctl),
		.fill_idx(near_cnt_q[NB-1:0]),
		.key(addr_q),
		.new_word(ins_word),
		.top_tag(addr_q),
		.top_word(ins_word),
		.bot_tag(near_bot_tag),
		.bot_word(near_bot_word),
		.start(start_q),
		.res_v(near_res_v),
		.res_hit(near_res_hit),
		.res_word(near_res_word)
	);

	tlfc_row #(
		.ENTRIES(FAR_ENTRIES),
		.ADDR_BITS(ADDR_BITS),
		.WORD_BITS(WORD_BITS)
	) u_far (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(far_ctl),
		.fill_idx(far_cnt_q[FB-1:0]),
		.key(addr_q),
		.new_word(ins_word),
		.top_tag(near_bot_tag),
		.top_word(near_bot_word),
		.bot_tag(far_bot_tag),
		.bot_word(far_bot_word),
		.start(start_q),
		.res_v(far_res_v),
		.res_hit(far_res_hit),
		.res_word(far_res_word)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata = M_DATA_BITS'(out_data_q);
	assign m_tuser = out_level_q;

	// On a shift the far row's slot 0 leaves the cache, so it must hold a written entry.
	a_commit_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> (near_done_q && far_done_q))
		else $error("update issued before both token chains finished");

	a_far_after_near: assert property (@(posedge clk) disable iff (!arst_n)
		(far_cnt_q != '0) |-> near_full)
		else $error("far level filled while near level had room");

	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && mode_q) |=> (m_tvalid && out_data_q == '0))
		else $error("write beat returned nonzero data");

	a_shift_drops_full: assert property (@(posedge clk) disable iff (!arst_n)
		far_ctl.shift |-> (near_full && far_full && !$isunknown({far_bot_tag, far_bot_word})))
		else $error("shift issued with a level not full");

endmodule
